@@ rtl/svd_pkg.sv @@
// Shared types, constants and branch metric function for the soft Viterbi decoder.
`default_nettype none
package svd_pkg;

    localparam int K         = 7;
    localparam int SW        = K - 1;
    localparam int NS        = 1 << SW;
    localparam int AW        = 7;
    localparam int PM_W      = 16;
    localparam int RAW_W     = PM_W + 2;
    localparam int BM_W      = 10;
    localparam int MAX_TB    = 64;

    localparam logic signed [RAW_W-1:0] FLOOR = -(RAW_W'(1) << (PM_W - 1));

    localparam logic [1:0] REG_DEPTH = 2'd0;
    localparam logic [1:0] REG_GEN1  = 2'd1;
    localparam logic [1:0] REG_GEN2  = 2'd2;

    typedef struct packed {
        logic          load;
        logic          acs_issue;
        logic          tb_issue;
        logic          commit;
        logic          emit;
        logic [AW-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic          need_tb;
        logic [AW-1:0] fill;
        logic          out_free;
    } sts_t;

    function automatic logic signed [BM_W-1:0] branch_metric(
        input logic [SW-1:0]     prev,
        input logic              b,
        input logic signed [7:0] s1,
        input logic signed [7:0] s2,
        input logic [K-1:0]      g1,
        input logic [K-1:0]      g2
    );
        logic [K-1:0]           word;
        logic signed [BM_W-1:0] a;
        logic signed [BM_W-1:0] c;
        word = {b, prev};
        a = BM_W'(s1);
        c = BM_W'(s2);
        if (!(^(word & g1)))
            a = -a;
        if (!(^(word & g2)))
            c = -c;
        return a + c;
    endfunction

endpackage
`default_nettype wire

@@ rtl/svd_ctrl.sv @@
// Sequencer: ACS sweep, history commit, traceback walk and result hand-off.
`default_nettype none
module svd_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire svd_pkg::sts_t sts,
    output svd_pkg::cmd_t      cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_ACS    = 6'b000010,
        ST_COMMIT = 6'b000100,
        ST_TB     = 6'b001000,
        ST_DRAIN  = 6'b010000,
        ST_EMIT   = 6'b100000
    } state_t;

    state_t                   state_reg, state_next;
    logic [svd_pkg::AW-1:0]   cnt_reg, cnt_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cmd           = '0;
        cmd.idx       = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_ACS;
                end
            end
            ST_ACS:
            begin
                cmd.acs_issue = (cnt_reg != svd_pkg::AW'(svd_pkg::NS));
                if (cnt_reg == svd_pkg::AW'(svd_pkg::NS))
                    state_next = ST_COMMIT;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                cnt_next   = sts.fill;
                state_next = sts.need_tb ? ST_TB : ST_IDLE;
            end
            ST_TB:
            begin
                cmd.tb_issue = 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_DRAIN;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            ST_DRAIN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/svd_dpath.sv @@
// Datapath: metric banks, ACS unit, decision and symbol history, traceback, output register.
`default_nettype none
module svd_dpath (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire svd_pkg::cmd_t cmd,
    output svd_pkg::sts_t      sts,
    input  wire logic [15:0]   s_tdata,
    input  wire logic          s_tuser,
    input  wire logic          cfg_valid,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [6:0]    cfg_data,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [15:0]        m_tdata
);

    localparam int SW    = svd_pkg::SW;
    localparam int AW    = svd_pkg::AW;
    localparam int RAW_W = svd_pkg::RAW_W;
    localparam int BM_W  = svd_pkg::BM_W;

    // config
    logic [6:0] depth_reg, gen1_reg, gen2_reg;

    // control state
    logic                 init_reg, bank_reg, out_valid_reg;
    logic [AW-1:0]        fill_reg, head_reg;
    logic                 acs_v_reg, tb_v_reg, tb_last_reg;

    // payload
    logic signed [7:0]       s1_reg, s2_reg;
    logic [SW-1:0]           acs_ns_reg;
    logic signed [RAW_W-1:0] maxacc_reg, maxprev_reg;
    logic [svd_pkg::NS-1:0]  row_reg;
    logic [SW-1:0]           st_reg;
    logic                    res_bit_reg;
    logic signed [BM_W-1:0]  res_bm_reg;
    logic [15:0]             out_data_reg;

    // memories
    logic [RAW_W-1:0]       pm_mem  [2*svd_pkg::NS];
    logic [svd_pkg::NS-1:0] dec_mem [1 << AW];
    logic [15:0]            sym_mem [1 << AW];

    logic signed [RAW_W-1:0] rd0_q, rd1_q;
    logic [svd_pkg::NS-1:0]  dec_q;
    logic [15:0]             sym_q;

    logic [SW-1:0]  p0;
    logic [AW-1:0]  tail, rd_row;
    logic [AW:0]    fill_inc;
    logic [6:0]     depth_sat;

    assign p0        = {cmd.idx[SW-2:0], 1'b0};
    assign tail      = head_reg + fill_reg;
    assign rd_row    = head_reg + cmd.idx;
    assign fill_inc  = {1'b0, fill_reg} + 1'b1;
    assign depth_sat = (depth_reg > 7'(svd_pkg::MAX_TB)) ? 7'(svd_pkg::MAX_TB) : depth_reg;

    assign sts.need_tb  = fill_inc > {1'b0, depth_sat};
    assign sts.fill     = fill_reg;
    assign sts.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ACS for the state in the pipeline slot
    logic [SW-1:0]           q0;
    logic signed [RAW_W-1:0] pm0, pm1, c0, c1, best;
    logic                    dsel, b_in;

    function automatic logic signed [RAW_W-1:0] norm(
        input logic signed [RAW_W-1:0] raw,
        input logic signed [RAW_W-1:0] mx
    );
        logic signed [RAW_W:0] diff;
        diff = (RAW_W+1)'(raw) - (RAW_W+1)'(mx);
        if (diff < (RAW_W+1)'(svd_pkg::FLOOR))
            return svd_pkg::FLOOR;
        return diff[RAW_W-1:0];
    endfunction

    always_comb
    begin
        q0   = {acs_ns_reg[SW-2:0], 1'b0};
        b_in = acs_ns_reg[SW-1];
        if (init_reg)
        begin
            pm0 = (q0 == '0) ? '0 : svd_pkg::FLOOR;
            pm1 = svd_pkg::FLOOR;
        end
        else
        begin
            pm0 = norm(rd0_q, maxprev_reg);
            pm1 = norm(rd1_q, maxprev_reg);
        end
        c0 = pm0 + RAW_W'(svd_pkg::branch_metric(q0, b_in, s1_reg, s2_reg,
                                                gen1_reg, gen2_reg));
        c1 = pm1 + RAW_W'(svd_pkg::branch_metric(q0 | SW'(1), b_in, s1_reg, s2_reg,
                                                gen1_reg, gen2_reg));
        best = (c0 > svd_pkg::FLOOR) ? c0 : svd_pkg::FLOOR;
        dsel = 1'b0;
        if (c1 > best)
        begin
            best = c1;
            dsel = 1'b1;
        end
    end

    // traceback step
    logic          dbit;
    logic [SW-1:0] st_step;
    assign dbit    = dec_q[st_reg];
    assign st_step = {st_reg[SW-2:0], dbit};

    always_ff @(posedge clk)
    begin
        rd0_q <= pm_mem[{bank_reg, p0}];
        rd1_q <= pm_mem[{bank_reg, p0 | SW'(1)}];
        dec_q <= dec_mem[rd_row];
        sym_q <= sym_mem[head_reg];
        if (acs_v_reg)
            pm_mem[{~bank_reg, acs_ns_reg}] <= best;
        if (cmd.commit)
        begin
            dec_mem[tail] <= row_reg;
            sym_mem[tail] <= {s1_reg, s2_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            s1_reg     <= s_tdata[7:0];
            s2_reg     <= s_tdata[15:8];
            maxacc_reg <= svd_pkg::FLOOR;
        end
        else if (acs_v_reg && best > maxacc_reg)
            maxacc_reg <= best;
        if (cmd.acs_issue)
            acs_ns_reg <= cmd.idx[SW-1:0];
        if (acs_v_reg)
            row_reg[acs_ns_reg] <= dsel;
        if (cmd.commit)
        begin
            maxprev_reg <= maxacc_reg;
            st_reg      <= '0;
        end
        else if (tb_v_reg && !tb_last_reg)
            st_reg <= st_step;
        if (tb_v_reg && tb_last_reg)
        begin
            res_bit_reg <= st_reg[SW-1];
            res_bm_reg  <= svd_pkg::branch_metric(st_step, st_reg[SW-1], sym_q[15:8],
                                                  sym_q[7:0], gen1_reg, gen2_reg);
        end
        if (cmd.emit)
            out_data_reg <= {5'b0, res_bm_reg, res_bit_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= 7'd32;
            gen1_reg      <= 7'd121;
            gen2_reg      <= 7'd91;
            init_reg      <= 1'b1;
            bank_reg      <= 1'b0;
            fill_reg      <= '0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
            acs_v_reg     <= 1'b0;
            tb_v_reg      <= 1'b0;
            tb_last_reg   <= 1'b0;
        end
        else
        begin
            acs_v_reg   <= cmd.acs_issue;
            tb_v_reg    <= cmd.tb_issue;
            tb_last_reg <= cmd.tb_issue && (cmd.idx == '0);
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    svd_pkg::REG_DEPTH: depth_reg <= cfg_data;
                    svd_pkg::REG_GEN1:  gen1_reg  <= cfg_data;
                    svd_pkg::REG_GEN2:  gen2_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.load && s_tuser)
            begin
                init_reg <= 1'b1;
                fill_reg <= '0;
            end
            else if (cmd.commit)
            begin
                init_reg <= 1'b0;
                bank_reg <= ~bank_reg;
                // a decision pops the oldest step, so the fill stays put
                if (!sts.need_tb)
                    fill_reg <= fill_inc[AW-1:0];
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
                head_reg      <= head_reg + 1'b1;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule
`default_nettype wire

@@ rtl/soft_viterbi_decoder_rate_half_unit.sv @@
// Top level of the rate 1/2 soft-decision Viterbi decoder.
//
// Input stream: one trellis step per transfer; s_tdata holds the two soft
// symbols, s_tuser the restart flag. Output stream: one decided bit per step
// once the stored history exceeds the traceback depth, with the survivor
// branch metric of that step. Config channel: cfg_index 0 traceback depth,
// 1 first generator, 2 second generator; always ready, write only when idle.
// Each step takes the accept in the idle state, one ACS sweep over all states
// (one state per cycle on a two-read metric memory, ping-pong banks), a commit,
// and when a bit is decided a traceback walk over the stored history (one
// history row read per cycle) plus the drain and emit states that hand the
// result over. s_tready is high only between steps.
// Reset restores the register defaults, the initial metrics and an empty
// history; no clearing sweep is needed. A result waits in the output
// register while m_tready is low; the next step is still accepted and only
// its own hand-off waits for the register to free up.
`default_nettype none
module soft_viterbi_decoder_rate_half_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // sym_first[7:0], sym_second[15:8]
    input  wire logic        s_tuser,   // restart
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // decoded_bit[0], survivor_metric[10:1], zeros
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [6:0]  cfg_data
);

    svd_pkg::cmd_t cmd;
    svd_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    svd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    svd_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
`default_nettype wire
